### rtl/cgg_pkg.sv
// shared widths and channel codes for the colour gradient generator
`timescale 1ns / 1ps
package cgg_pkg;

  localparam int COLOR_W = 8;
  localparam int COUNT_W = 7;
  localparam int QUOT_W  = 8;

  typedef logic [COLOR_W-1:0] color_t;
  typedef logic [COUNT_W-1:0] count_t;

  // colour channel currently being interpolated
  typedef enum logic [1:0] {
    CH_RED   = 2'd0,
    CH_GREEN = 2'd1,
    CH_BLUE  = 2'd2
  } chan_t;

endpackage

### rtl/cgg_req_if.sv
// request and colour channels of the colour gradient generator
`timescale 1ns / 1ps
interface cgg_req_if import cgg_pkg::*; ();
  logic   valid;
  logic   ready;
  color_t start_red;
  color_t start_green;
  color_t start_blue;
  color_t end_red;
  color_t end_green;
  color_t end_blue;
  count_t step_count;

  modport source (
    output valid, start_red, start_green, start_blue,
    output end_red, end_green, end_blue, step_count,
    input  ready
  );
  modport sink (
    input  valid, start_red, start_green, start_blue,
    input  end_red, end_green, end_blue, step_count,
    output ready
  );
endinterface

interface cgg_color_if import cgg_pkg::*; ();
  logic   valid;
  logic   ready;
  color_t red;
  color_t green;
  color_t blue;
  logic   last_color;

  modport source (output valid, red, green, blue, last_color, input ready);
  modport sink (input valid, red, green, blue, last_color, output ready);
endinterface

### rtl/cgg_div.sv
// shared restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module cgg_div import cgg_pkg::*; #(
  parameter int DEN_W = 7
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [QUOT_W+DEN_W-1:0] numer,
  input  logic [DEN_W-1:0]        denom,
  output logic                    done,
  output logic [QUOT_W-1:0]       quot
);

  localparam int CNT_W = $clog2(QUOT_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QUOT_W - 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dreg;
  logic [QUOT_W-1:0] shreg;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  // partial remainder stays below the divisor, so one extra bit suffices
  assign trial = {rem, shreg[QUOT_W-1]};
  assign diff  = trial - {1'b0, dreg};
  assign ge    = trial >= {1'b0, dreg};
  assign quot  = shreg;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == CNT_LAST);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= numer[QUOT_W+DEN_W-1:QUOT_W];
      shreg <= numer[QUOT_W-1:0];
      dreg  <= denom;
    end else if (busy) begin
      rem   <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      shreg <= {shreg[QUOT_W-2:0], ge};
    end
  end

endmodule

### rtl/color_gradient_generator_core.sv
// top level of the linear rgb colour gradient generator
`timescale 1ns / 1ps
// Takes one request (start colour, end colour, step count) and returns a run
// of colours: the start colour, the interior colours i = 1 .. n-2 with each
// channel start + round(i*(end-start)/(n-1)), ties away from zero, and
// finally the end colour flagged with last_color. The count is clamped to
// 2 .. MAX_STEPS. All interior channels go through one shared restoring
// divider that yields a quotient bit per cycle; each channel passes through
// operand issue, 8 divide steps and result write-back, and an interior colour
// is offered on the output once its blue channel is written back. The output
// waits for the sink to be ready. A new request is taken only once the last
// colour of the previous run has been handed over.
module color_gradient_generator_core import cgg_pkg::*; #(
  parameter int MAX_STEPS = 64
) (
  input  logic              clk,
  input  logic              rst,
  cgg_req_if.sink           req,
  cgg_color_if.source       color
);

  localparam int IDX_W = (MAX_STEPS > 2) ? $clog2(MAX_STEPS) : 1;
  localparam int DEN_W = IDX_W + 1;
  localparam int NUM_W = QUOT_W + DEN_W;
  localparam int PROD_W = COLOR_W + IDX_W;
  localparam count_t MAX_N = COUNT_W'(MAX_STEPS);
  localparam count_t MIN_N = COUNT_W'(2);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ISSUE = 4'b0010,
    ST_WAIT  = 4'b0100,
    ST_OUT   = 4'b1000
  } state_t;

  state_t state, state_next;

  // latched request
  color_t start_r, start_g, start_b;
  color_t end_r, end_g, end_b;
  logic [IDX_W-1:0] last_idx;   // n - 1
  logic [IDX_W-1:0] idx;        // colour currently being produced
  chan_t            ch;

  // output register
  color_t out_r, out_g, out_b;
  logic   out_last;

  // operand path for the selected channel
  color_t           s_sel, e_sel, mag, chan_val;
  logic             neg;
  logic [PROD_W-1:0] prod;
  logic [NUM_W-1:0] numer;
  logic [DEN_W-1:0] denom;
  logic             div_start, div_done;
  logic [QUOT_W-1:0] div_quot;
  count_t           n_eff;
  logic             req_take, col_take, at_end;

  assign req.ready   = (state == ST_IDLE);
  assign color.valid = (state == ST_OUT);
  assign color.red        = out_r;
  assign color.green      = out_g;
  assign color.blue       = out_b;
  assign color.last_color = out_last;

  assign req_take = req.valid && req.ready;
  assign col_take = color.valid && color.ready;
  // next colour is the end colour
  assign at_end = ({1'b0, idx} + 1'b1) == {1'b0, last_idx};

  // clamp the step count to 2 .. MAX_STEPS
  always_comb begin
    n_eff = req.step_count;
    if (req.step_count < MIN_N) begin
      n_eff = MIN_N;
    end else if (req.step_count > MAX_N) begin
      n_eff = MAX_N;
    end
  end

  always_comb begin
    case (ch)
      CH_RED: begin
        s_sel = start_r;
        e_sel = end_r;
      end
      CH_GREEN: begin
        s_sel = start_g;
        e_sel = end_g;
      end
      CH_BLUE: begin
        s_sel = start_b;
        e_sel = end_b;
      end
      default: begin
        s_sel = start_r;
        e_sel = end_r;
      end
    endcase
  end

  // numerator 2*|e-s|*i + (n-1) over divisor 2*(n-1) gives the rounded step
  assign neg   = e_sel < s_sel;
  assign mag   = neg ? (s_sel - e_sel) : (e_sel - s_sel);
  assign prod  = PROD_W'(mag) * PROD_W'(idx);
  assign numer = {prod, 1'b0} + NUM_W'(last_idx);
  assign denom = {last_idx, 1'b0};
  assign div_start = (state == ST_ISSUE);

  // interpolated value never leaves the start..end span, so 8 bits wrap cleanly
  assign chan_val = neg ? (s_sel - div_quot) : (s_sel + div_quot);

  cgg_div #(
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer (numer),
    .denom (denom),
    .done  (div_done),
    .quot  (div_quot)
  );

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_take) begin
          state_next = ST_OUT;
        end
      end
      ST_ISSUE: begin
        state_next = ST_WAIT;
      end
      ST_WAIT: begin
        if (div_done) begin
          state_next = (ch == CH_BLUE) ? ST_OUT : ST_ISSUE;
        end
      end
      ST_OUT: begin
        if (col_take) begin
          if (out_last) begin
            state_next = ST_IDLE;
          end else if (!at_end) begin
            state_next = ST_ISSUE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
      ch    <= CH_RED;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          if (req_take) begin
            idx <= '0;
            ch  <= CH_RED;
          end
        end
        ST_WAIT: begin
          if (div_done) begin
            case (ch)
              CH_RED:   ch <= CH_GREEN;
              CH_GREEN: ch <= CH_BLUE;
              default:  ch <= CH_RED;
            endcase
          end
        end
        ST_OUT: begin
          if (col_take && !out_last) begin
            idx <= idx + 1'b1;
            ch  <= CH_RED;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (req_take) begin
          start_r  <= req.start_red;
          start_g  <= req.start_green;
          start_b  <= req.start_blue;
          end_r    <= req.end_red;
          end_g    <= req.end_green;
          end_b    <= req.end_blue;
          last_idx <= IDX_W'(n_eff - 1'b1);
          out_r    <= req.start_red;
          out_g    <= req.start_green;
          out_b    <= req.start_blue;
          out_last <= 1'b0;
        end
      end
      ST_WAIT: begin
        if (div_done) begin
          case (ch)
            CH_RED:   out_r <= chan_val;
            CH_GREEN: out_g <= chan_val;
            CH_BLUE:  out_b <= chan_val;
            default: begin
            end
          endcase
        end
      end
      ST_OUT: begin
        if (col_take && !out_last && at_end) begin
          out_r    <= end_r;
          out_g    <= end_g;
          out_b    <= end_b;
          out_last <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // checks
  a_no_req_while_busy: assert property (@(posedge clk) disable iff (rst)
    color.valid |-> !req.ready)
    else $error("request taken while a colour is pending");

  a_first_is_start: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=>
      (color.valid && !color.last_color && color.red == $past(req.start_red)
       && color.blue == $past(req.start_blue)))
    else $error("first colour of a run is not the start colour");

  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    (color.valid && color.ready && color.last_color) |=> req.ready)
    else $error("block not idle after the closing colour");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_WAIT))
    else $error("divider finished outside the wait state");

endmodule
